[rtl/core/scc_pkg.sv]
// Package with the shared constants, payload types and control structs of the coverage counter.
`default_nettype none

package scc_pkg;

	// Grid geometry and coverage counter size.
	localparam int unsigned GRID_DIM  = 1024;
	localparam int unsigned CELL_BITS = 4;
	localparam int unsigned CELLS     = GRID_DIM * GRID_DIM;
	localparam int unsigned ADDR_W    = $clog2(CELLS);

	// Fixed field widths.
	localparam int unsigned COORD_W = 10;
	localparam int unsigned HOT_W   = 21;
	localparam int unsigned THR_W   = 4;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned DIR_W   = 2;

	// Width that holds both a cell value plus one and any threshold.
	localparam int unsigned CMP_W = ((CELL_BITS > THR_W) ? CELL_BITS : THR_W) + 1;

	localparam logic [CELL_BITS-1:0] CELL_MAX = '1;
	localparam logic [HOT_W-1:0]     HOT_MAX  = '1;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_AXIS    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DIAG    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

	// Item actions.
	localparam logic ACT_DRAW  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// Per-axis step direction.
	localparam logic [DIR_W-1:0] DIR_HOLD = 2'd0;
	localparam logic [DIR_W-1:0] DIR_INC  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DEC  = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAG_EN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

	// Input item.
	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} seg_item_t;

	// Result item.
	typedef struct packed {
		logic [HOT_W-1:0]  hot_cells;
		logic [KIND_W-1:0] segment_kind;
	} res_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_step;
		logic draw_step;
		logic res_load;
	} scc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic item_clear;
		logic item_ignored;
		logic clr_last;
		logic draw_last;
	} scc_stat_t;

endpackage

`default_nettype wire

[rtl/core/scc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module scc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/scc_datapath.sv]
// Datapath: configuration registers, segment walker, coverage RAM update and hot count.
`default_nettype none

module scc_datapath import scc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire scc_cmd_t              cmd,
	output scc_stat_t                  stat,
	input  wire seg_item_t             seg,
	output res_item_t                  res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic                 diag_en_q;
	logic [THR_W-1:0]     thr_q;
	logic [COORD_W-1:0]   x_q, y_q;
	logic [DIR_W-1:0]     xdir_q, ydir_q;
	logic [COORD_W-1:0]   steps_q;
	logic [KIND_W-1:0]    kind_q;
	logic [HOT_W-1:0]     hot_q;
	logic [ADDR_W-1:0]    clr_addr_q;
	logic                 rd_valid_s1;
	logic [ADDR_W-1:0]    addr_s1;
	res_item_t            res_q;

	logic                 dx_neg, dy_neg;
	logic [COORD_W-1:0]   adx, ady;
	logic                 dx_zero, dy_zero;
	logic [KIND_W-1:0]    kind_in;
	logic [COORD_W-1:0]   steps_in;
	logic [DIR_W-1:0]     xdir_in, ydir_in;
	logic [COORD_W-1:0]   x_next, y_next;
	logic                 in_range;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_en;
	logic [CELL_BITS-1:0] old_cell;
	logic [CELL_BITS-1:0] new_cell;
	logic                 cell_wr;
	logic [CMP_W-1:0]     new_ext, thr_eff;
	logic                 hot_inc;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [CELL_BITS-1:0] ram_wdata;

	// Classify the incoming segment from its endpoint differences.
	always_comb begin
		dx_neg  = seg.end_x < seg.start_x;
		dy_neg  = seg.end_y < seg.start_y;
		adx     = dx_neg ? (seg.start_x - seg.end_x) : (seg.end_x - seg.start_x);
		ady     = dy_neg ? (seg.start_y - seg.end_y) : (seg.end_y - seg.start_y);
		dx_zero = (adx == '0);
		dy_zero = (ady == '0);
		if (dx_zero || dy_zero) begin
			kind_in  = KIND_AXIS;
			steps_in = adx | ady;
		end else if ((adx == ady) && diag_en_q) begin
			kind_in  = KIND_DIAG;
			steps_in = adx;
		end else begin
			kind_in  = KIND_IGNORED;
			steps_in = adx;
		end
		xdir_in = dx_zero ? DIR_HOLD : (dx_neg ? DIR_DEC : DIR_INC);
		ydir_in = dy_zero ? DIR_HOLD : (dy_neg ? DIR_DEC : DIR_INC);
	end

	assign stat.item_clear   = (seg.action == ACT_CLEAR);
	assign stat.item_ignored = (kind_in == KIND_IGNORED);
	assign stat.draw_last    = (steps_q == '0);
	assign stat.clr_last     = (clr_addr_q == ADDR_W'(CELLS - 1));

	// Next walker position along each axis.
	always_comb begin
		case (xdir_q)
			DIR_INC: x_next = x_q + 1'b1;
			DIR_DEC: x_next = x_q - 1'b1;
			default: x_next = x_q;
		endcase
		case (ydir_q)
			DIR_INC: y_next = y_q + 1'b1;
			DIR_DEC: y_next = y_q - 1'b1;
			default: y_next = y_q;
		endcase
	end

	// Cells outside the grid are stepped over without a memory access.
	assign in_range = (32'(x_q) < GRID_DIM) && (32'(y_q) < GRID_DIM);
	assign rd_addr  = ADDR_W'(32'(x_q) * GRID_DIM + 32'(y_q));
	assign rd_en    = cmd.draw_step && in_range;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_en_q <= 1'b1;
			thr_q     <= THR_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIAG_EN:   diag_en_q <= cfg_data[0];
				CFG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Walker registers: loaded on a transfer, advanced once per drawn cell.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= seg.start_x;
			y_q     <= seg.start_y;
			xdir_q  <= xdir_in;
			ydir_q  <= ydir_in;
			steps_q <= steps_in;
		end else if (cmd.draw_step) begin
			x_q     <= x_next;
			y_q     <= y_next;
			steps_q <= steps_q - 1'b1;
		end
	end

	// Kind of the item in progress.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= stat.item_clear ? KIND_CLEARED : kind_in;
		end
	end

	// Read stage of the read-modify-write pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

	// Update stage: increment unless saturated, count the threshold crossing.
	always_comb begin
		new_cell = old_cell + 1'b1;
		cell_wr  = rd_valid_s1 && (old_cell != CELL_MAX);
		new_ext  = CMP_W'(old_cell) + 1'b1;
		thr_eff  = (thr_q == '0) ? CMP_W'(1) : CMP_W'(thr_q);
		hot_inc  = cell_wr && (new_ext == thr_eff) && (hot_q != HOT_MAX);
	end

	// Hot cell count, zeroed by a clear item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_q <= '0;
		end else if (cmd.load && stat.item_clear) begin
			hot_q <= '0;
		end else if (hot_inc) begin
			hot_q <= hot_q + 1'b1;
		end
	end

	// Clear sweep address, wrapping to zero after the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= stat.clr_last ? '0 : clr_addr_q + 1'b1;
		end
	end

	// The sweep and the update stage never write in the same cycle.
	always_comb begin
		ram_we    = cmd.clr_step || cell_wr;
		ram_waddr = cmd.clr_step ? clr_addr_q : addr_s1;
		ram_wdata = cmd.clr_step ? '0 : new_cell;
	end

	scc_ram #(
		.WIDTH (CELL_BITS),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (old_cell)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.hot_cells    <= hot_q;
			res_q.segment_kind <= kind_q;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

[rtl/core/scc_ctrl.sv]
// Controller state machine: item sequencing, clear sweeps and result handoff.
`default_nettype none

module scc_ctrl import scc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      seg_valid,
	output logic           seg_stall,
	output logic           res_valid,
	input  wire logic      res_stall,
	input  wire scc_stat_t stat,
	output scc_cmd_t       cmd
);

	localparam logic [2:0] S_BOOT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CLEAR = 3'd2;
	localparam logic [2:0] S_DRAW  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       res_valid_q;
	logic       accept;
	logic       res_free;

	assign seg_stall = (state_q != S_IDLE);
	assign accept    = seg_valid && (state_q == S_IDLE);
	assign res_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.load      = accept;
		unique case (state_q)
			S_BOOT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (stat.item_clear) begin
						state_d = S_CLEAR;
					end else if (stat.item_ignored) begin
						state_d = S_DONE;
					end else begin
						state_d = S_DRAW;
					end
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_DRAW: begin
				cmd.draw_step = 1'b1;
				if (stat.draw_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts with a sweep of the whole grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on a load, dropped after its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/core/segment_coverage_counter_top.sv]
// Top level of the segment coverage counter: controller and datapath.
//
// Channel   Direction  Handshake              Payload
// seg       in         seg_valid / seg_stall  seg_item_t: action, endpoints
// res       out        res_valid / res_stall  res_item_t: hot_cells, segment_kind
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A drawn segment of n cells gets one read-modify-write of the
// coverage RAM per cell, pipelined one cell per cycle behind its registered read port.
// An ignored segment never touches the RAM. A clear item sweeps the RAM one cell per cycle,
// visiting all GRID_DIM * GRID_DIM cells. After reset the same sweep runs to its end
// before the first item transfer.
// The next item is taken while a result waits in the output register; a stalled
// result holds the following item at its end until the register frees.
`default_nettype none

module segment_coverage_counter_top import scc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  seg_valid,
	output logic                       seg_stall,
	input  wire seg_item_t             seg,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_item_t                  res,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	scc_cmd_t  cmd;
	scc_stat_t stat;

	// Registers are written whenever requested.
	assign cfg_ready = 1'b1;

	scc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	scc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.seg       (seg),
		.res       (res),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
